// ----- rtl/core/uaw_pkg.sv -----
// shared types and constants for the ustar archive walker
`default_nettype none
package uaw_pkg;

  localparam int unsigned MaxNameLen = 64;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned NameDepth  = MaxNameLen + 2;
  localparam int unsigned NameAw     = $clog2(NameDepth);
  localparam int unsigned SizeW      = 36;

  localparam logic [1:0] CmdByte    = 2'd0;
  localparam logic [1:0] CmdEnd     = 2'd1;
  localparam logic [1:0] CmdRestart = 2'd2;

  localparam logic [1:0] KindName    = 2'd0;
  localparam logic [1:0] KindContent = 2'd1;
  localparam logic [1:0] KindEnd     = 2'd2;
  localparam logic [1:0] KindError   = 2'd3;

  localparam logic [3:0] ErrTruncHdr  = 4'd0;
  localparam logic [3:0] ErrNoTerm2   = 4'd1;
  localparam logic [3:0] ErrMagic     = 4'd2;
  localparam logic [3:0] ErrChkDigit  = 4'd3;
  localparam logic [3:0] ErrChkSum    = 4'd4;
  localparam logic [3:0] ErrType      = 4'd5;
  localparam logic [3:0] ErrSizeDigit = 4'd6;
  localparam logic [3:0] ErrTruncDir  = 4'd7;
  localparam logic [3:0] ErrTruncData = 4'd8;
  localparam logic [3:0] ErrName      = 4'd9;
  localparam logic [3:0] ErrEmpty     = 4'd10;

  typedef enum logic [3:0] {
    StHeader, StTerm2, StDir, StDirPad, StContent, StFilePad,
    StHalt, StName, StPrime, StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       clear_all;
    logic       hdr_byte;
    logic       data_byte;
    logic       pad_byte;
    logic       dir_byte;
    logic       load_size;
    logic       count_file;
    logic       name_start;
    logic       name_step;
    logic       out_load;
    logic [1:0] out_kind;
    logic [3:0] out_err;
    logic       out_name;
    logic       out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       off_last;
    logic       off_wrap;
    logic       all_zero;
    logic       magic_bad;
    logic       chk_bad;
    logic       chk_mismatch;
    logic [1:0] type_cls;
    logic       size_bad;
    logic       size_zero;
    logic       rem_one;
    logic       name_bad;
    logic       name_fin;
    logic       files_zero;
  } dp_sts_t;

  localparam logic [1:0] TypeFile = 2'd0;
  localparam logic [1:0] TypeDir  = 2'd1;
  localparam logic [1:0] TypeBad  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/uaw_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module uaw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 66
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/uaw_datapath.sv -----
// header field registers, name store, counters and output register
`default_nettype none
module uaw_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire uaw_pkg::dp_cmd_t cmd_i,
  input  wire logic [7:0]      byte_i,
  output uaw_pkg::dp_sts_t     sts_o,
  output logic [1:0]           kind_o,
  output logic [7:0]           data_o,
  output logic [35:0]          entry_size_o,
  output logic [15:0]          file_count_o,
  output logic [3:0]           error_code_o,
  output logic                 last_o
);
  localparam int unsigned Aw = uaw_pkg::NameAw;

  logic [8:0]  off_q, off_d;
  logic [16:0] sum_q, sum_d;
  logic [23:0] chk_q, chk_d;
  logic [35:0] size_q, size_d;
  logic [35:0] rem_q, rem_d;
  logic [7:0]  type_q, type_d;
  logic [6:0]  nlen_q, nlen_d;
  logic        allz_q, allz_d, nend_q, nend_d, sllate_q, sllate_d, sllead_q, sllead_d;
  logic        mbad_q, mbad_d, cbad_q, cbad_d, send_q, send_d, sbad_q, sbad_d;
  logic        n0dot_q, n0dot_d, n1sl_q, n1sl_d;
  logic [uaw_pkg::CountBits-1:0] files_q, files_d;
  logic [6:0]  rd_q, rd_d, left_q, left_d;
  logic [7:0]  name_rd;
  logic        we;
  logic [7:0]  magic_ch;
  logic        in_chk, in_size, strip;
  logic [6:0]  len;

  always_comb begin
    unique case (off_q)
      9'd257:  magic_ch = 8'h75;
      9'd258:  magic_ch = 8'h73;
      9'd259:  magic_ch = 8'h74;
      9'd260:  magic_ch = 8'h61;
      default: magic_ch = 8'h72;
    endcase
  end

  assign in_chk  = (off_q >= 9'd148) && (off_q < 9'd156);
  assign in_size = (off_q >= 9'd124) && (off_q < 9'd136);
  assign we = cmd_i.hdr_byte && (off_q < 9'd100) && !(nend_q && off_q != 9'd0) &&
              (byte_i != 8'd0) && (off_q < 9'(uaw_pkg::NameDepth));
  assign strip = (nlen_q >= 7'd2) && n0dot_q && n1sl_q;
  assign len   = strip ? nlen_q - 7'd2 : nlen_q;

  always_comb begin
    off_d = off_q; sum_d = sum_q; chk_d = chk_q; size_d = size_q; rem_d = rem_q;
    type_d = type_q; nlen_d = nlen_q; allz_d = allz_q; nend_d = nend_q;
    sllate_d = sllate_q; sllead_d = sllead_q; mbad_d = mbad_q; cbad_d = cbad_q;
    send_d = send_q; sbad_d = sbad_q; n0dot_d = n0dot_q; n1sl_d = n1sl_q;
    files_d = files_q; rd_d = rd_q; left_d = left_q;
    if (cmd_i.hdr_byte) begin
      if (off_q == 9'd0) begin
        sum_d = '0; chk_d = '0; size_d = '0; type_d = '0; nlen_d = '0;
        allz_d = 1'b1; nend_d = 1'b0; sllate_d = 1'b0; sllead_d = 1'b0;
        mbad_d = 1'b0; cbad_d = 1'b0; send_d = 1'b0; sbad_d = 1'b0;
        n0dot_d = 1'b0; n1sl_d = 1'b0;
      end
      if (byte_i != 8'd0) allz_d = 1'b0;
      sum_d = (off_q == 9'd0 ? 17'd0 : sum_q) + (in_chk ? 17'd32 : {9'd0, byte_i});
      if (off_q < 9'd100 && !(nend_q && off_q != 9'd0)) begin
        if (byte_i == 8'd0) begin
          nend_d = 1'b1;
        end else begin
          if (byte_i == 8'h2f) begin
            if (off_q < 9'd2) sllead_d = 1'b1;
            else sllate_d = 1'b1;
          end
          if (off_q == 9'd0) n0dot_d = (byte_i == 8'h2e);
          if (off_q == 9'd1) n1sl_d = (byte_i == 8'h2f);
          nlen_d = (off_q == 9'd0 ? 7'd0 : nlen_q) + 7'd1;
        end
      end
      if (in_size && !send_q && !sbad_q) begin
        if (byte_i == 8'h20 || byte_i == 8'd0) send_d = 1'b1;
        else if (byte_i < 8'h30 || byte_i > 8'h37) sbad_d = 1'b1;
        else size_d = {size_q[32:0], byte_i[2:0]};
      end
      if (in_chk && byte_i != 8'h20 && byte_i != 8'd0) begin
        if (byte_i < 8'h30 || byte_i > 8'h37) cbad_d = 1'b1;
        else chk_d = {chk_q[20:0], byte_i[2:0]};
      end
      if (off_q == 9'd156) type_d = byte_i;
      if (off_q >= 9'd257 && off_q < 9'd262 && byte_i != magic_ch) mbad_d = 1'b1;
      off_d = off_q + 9'd1;
    end
    if (cmd_i.data_byte || cmd_i.dir_byte) rem_d = rem_q - 36'd1;
    if (cmd_i.data_byte || cmd_i.dir_byte || cmd_i.pad_byte) off_d = off_q + 9'd1;
    if (cmd_i.load_size) rem_d = size_q;
    if (cmd_i.count_file && files_q != '1) files_d = files_q + 1'b1;
    if (cmd_i.name_start) begin
      rd_d = strip ? 7'd2 : 7'd0;
      left_d = len;
    end
    if (cmd_i.name_step) begin
      rd_d = rd_q + 7'd1;
      left_d = left_q - 7'd1;
    end
    if (cmd_i.clear_all) begin
      off_d = '0; rem_d = '0; files_d = '0; allz_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; files_q <= '0; rem_q <= '0; allz_q <= 1'b1;
    end else begin
      off_q <= off_d; files_q <= files_d; rem_q <= rem_d; allz_q <= allz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d; chk_q <= chk_d; size_q <= size_d; type_q <= type_d;
    nlen_q <= nlen_d; nend_q <= nend_d; sllate_q <= sllate_d; sllead_q <= sllead_d;
    mbad_q <= mbad_d; cbad_q <= cbad_d; send_q <= send_d; sbad_q <= sbad_d;
    n0dot_q <= n0dot_d; n1sl_q <= n1sl_d; rd_q <= rd_d; left_q <= left_d;
  end

  uaw_ram #(.Width(8), .Depth(uaw_pkg::NameDepth)) u_name (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(off_q[Aw-1:0]),
    .wdata_i(byte_i),
    .raddr_i(rd_q[Aw-1:0]),
    .rdata_o(name_rd)
  );

  always_comb begin
    sts_o.off_last     = (off_q == 9'd511);
    sts_o.off_wrap     = (off_q == 9'd511);
    sts_o.all_zero     = allz_q;
    sts_o.magic_bad    = mbad_q;
    sts_o.chk_bad      = cbad_q;
    sts_o.chk_mismatch = ({7'd0, sum_q} != chk_q);
    if (type_q == 8'h30 || type_q == 8'h00) sts_o.type_cls = uaw_pkg::TypeFile;
    else if (type_q == 8'h35)               sts_o.type_cls = uaw_pkg::TypeDir;
    else                                    sts_o.type_cls = uaw_pkg::TypeBad;
    sts_o.size_bad   = sbad_q;
    sts_o.size_zero  = (size_q == '0);
    sts_o.rem_one    = (rem_q == 36'd1);
    sts_o.name_bad   = (len == 7'd0) || sllate_q || (!strip && sllead_q) ||
                       (len > 7'(uaw_pkg::MaxNameLen));
    sts_o.name_fin   = (left_q == 7'd1);
    sts_o.files_zero = (files_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_o       <= cmd_i.out_kind;
      data_o       <= cmd_i.out_name ? name_rd :
                      (cmd_i.out_kind == uaw_pkg::KindContent ? byte_i : 8'd0);
      entry_size_o <= (cmd_i.out_name && cmd_i.out_last) ? size_q : 36'd0;
      error_code_o <= cmd_i.out_err;
      last_o       <= cmd_i.out_last;
      file_count_o <= 16'(files_q);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/uaw_ctrl.sv -----
// walker phase controller and handshake control
`default_nettype none
module uaw_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       cmd_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire uaw_pkg::dp_sts_t sts_i,
  output uaw_pkg::dp_cmd_t      cmd_o
);
  uaw_pkg::state_e st_q, st_d, ret_q, ret_d;
  logic ov_q, ov_d;
  logic acc, free;

  assign free = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= uaw_pkg::StHeader; ret_q <= uaw_pkg::StHeader; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; ov_q <= ov_d;
    end
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    in_ready_o = free && (st_q != uaw_pkg::StName) && (st_q != uaw_pkg::StPrime) &&
                 (st_q != uaw_pkg::StOut);
    acc = in_valid_i && in_ready_o;
    unique case (st_q)
      uaw_pkg::StPrime: st_d = uaw_pkg::StName;
      uaw_pkg::StName: begin
        if (free) begin
          cmd_o.out_load = 1'b1; cmd_o.out_name = 1'b1; ov_d = 1'b1;
          cmd_o.out_kind = uaw_pkg::KindName;
          cmd_o.out_last = sts_i.name_fin;
          cmd_o.name_step = 1'b1;
          st_d = sts_i.name_fin ? uaw_pkg::StOut : uaw_pkg::StPrime;
        end
      end
      uaw_pkg::StOut: begin
        if (sts_i.size_zero) begin
          cmd_o.count_file = 1'b1; st_d = uaw_pkg::StHeader;
        end else begin
          st_d = uaw_pkg::StContent;
        end
      end
      default: begin
        if (acc) begin
          priority case (cmd_i)
            uaw_pkg::CmdRestart: begin
              cmd_o.clear_all = 1'b1; st_d = uaw_pkg::StHeader;
            end
            uaw_pkg::CmdEnd: begin
              if (st_q != uaw_pkg::StHalt) begin
                cmd_o.out_load = 1'b1; ov_d = 1'b1; st_d = uaw_pkg::StHalt;
                cmd_o.out_kind = uaw_pkg::KindError;
                unique case (st_q)
                  uaw_pkg::StHeader: cmd_o.out_err = uaw_pkg::ErrTruncHdr;
                  uaw_pkg::StTerm2:  cmd_o.out_err = uaw_pkg::ErrNoTerm2;
                  uaw_pkg::StDir, uaw_pkg::StDirPad: cmd_o.out_err = uaw_pkg::ErrTruncDir;
                  default:           cmd_o.out_err = uaw_pkg::ErrTruncData;
                endcase
              end
            end
            uaw_pkg::CmdByte: begin
              unique case (st_q)
                uaw_pkg::StHeader: begin
                  cmd_o.hdr_byte = 1'b1;
                  if (sts_i.off_last) st_d = uaw_pkg::StOut;
                  if (sts_i.off_last) st_d = uaw_pkg::StHeader;
                end
                uaw_pkg::StTerm2: begin
                  cmd_o.pad_byte = 1'b1;
                  if (sts_i.off_wrap) begin
                    cmd_o.out_load = 1'b1; ov_d = 1'b1; st_d = uaw_pkg::StHalt;
                    cmd_o.out_kind = sts_i.files_zero ? uaw_pkg::KindError
                                                      : uaw_pkg::KindEnd;
                    cmd_o.out_err = sts_i.files_zero ? uaw_pkg::ErrEmpty
                                                     : uaw_pkg::ErrTruncHdr;
                  end
                end
                uaw_pkg::StDir, uaw_pkg::StContent: begin
                  if (st_q == uaw_pkg::StContent) begin
                    cmd_o.data_byte = 1'b1; cmd_o.out_load = 1'b1; ov_d = 1'b1;
                    cmd_o.out_kind = uaw_pkg::KindContent;
                    cmd_o.out_last = sts_i.rem_one;
                  end else begin
                    cmd_o.dir_byte = 1'b1;
                  end
                  if (sts_i.rem_one) begin
                    if (sts_i.off_wrap) begin
                      cmd_o.count_file = (st_q == uaw_pkg::StContent);
                      st_d = uaw_pkg::StHeader;
                    end else begin
                      st_d = (st_q == uaw_pkg::StContent) ? uaw_pkg::StFilePad
                                                         : uaw_pkg::StDirPad;
                    end
                  end
                end
                uaw_pkg::StDirPad, uaw_pkg::StFilePad: begin
                  cmd_o.pad_byte = 1'b1;
                  if (sts_i.off_wrap) begin
                    cmd_o.count_file = (st_q == uaw_pkg::StFilePad);
                    st_d = uaw_pkg::StHeader;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          if (cmd_o.hdr_byte && sts_i.off_last) st_d = uaw_pkg::StOut;
        end
        if (st_q == uaw_pkg::StOut) st_d = uaw_pkg::StOut;
      end
    endcase
    ret_d = ret_q;
    // header check runs the cycle after the last header byte
    if (st_q == uaw_pkg::StHeader && acc && cmd_o.hdr_byte && sts_i.off_last) begin
      st_d = uaw_pkg::StOut;
      ret_d = uaw_pkg::StOut;
    end
    if (st_q == uaw_pkg::StOut && ret_q == uaw_pkg::StOut) begin
      cmd_o = '0;
      ret_d = uaw_pkg::StHeader;
      if (sts_i.all_zero) begin
        st_d = uaw_pkg::StTerm2;
      end else begin
        st_d = uaw_pkg::StHalt;
        cmd_o.out_kind = uaw_pkg::KindError;
        priority if (sts_i.magic_bad)              cmd_o.out_err = uaw_pkg::ErrMagic;
        else if (sts_i.chk_bad)                    cmd_o.out_err = uaw_pkg::ErrChkDigit;
        else if (sts_i.chk_mismatch)               cmd_o.out_err = uaw_pkg::ErrChkSum;
        else if (sts_i.type_cls == uaw_pkg::TypeBad) cmd_o.out_err = uaw_pkg::ErrType;
        else if (sts_i.size_bad)                   cmd_o.out_err = uaw_pkg::ErrSizeDigit;
        else if (sts_i.type_cls == uaw_pkg::TypeDir) begin
          st_d = sts_i.size_zero ? uaw_pkg::StHeader : uaw_pkg::StDir;
          cmd_o.load_size = 1'b1;
        end else if (sts_i.name_bad)               cmd_o.out_err = uaw_pkg::ErrName;
        else begin
          st_d = uaw_pkg::StPrime;
          cmd_o.load_size = 1'b1; cmd_o.name_start = 1'b1;
        end
        if (st_d == uaw_pkg::StHalt) begin
          if (free) begin
            cmd_o.out_load = 1'b1; ov_d = 1'b1;
          end else begin
            st_d = uaw_pkg::StOut; ret_d = uaw_pkg::StOut; cmd_o = '0;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/ustar_archive_walker.sv -----
// top level of the ustar archive walker
// throughput: one archive byte per cycle while no result is held back and no header
// check or name output runs; the header check follows byte 511, and a file name is
// then read out through the registered name store read port, each byte primed first
// results leave through one output register; input stalls while it is full and not taken
// reset: asynchronous, active low, walker returns to the header phase
`default_nettype none
module ustar_archive_walker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_o,
  output logic [35:0]      entry_size_o,
  output logic [15:0]      file_count_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);
  uaw_pkg::dp_cmd_t cmd;
  uaw_pkg::dp_sts_t sts;

  uaw_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(cmd_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  uaw_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .byte_i(data_byte_i), .sts_o(sts),
    .kind_o(kind_o), .data_o(data_o), .entry_size_o(entry_size_o),
    .file_count_o(file_count_o), .error_code_o(error_code_o), .last_o(last_o)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i)) else $error("result overwritten");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.hdr_byte, cmd.data_byte, cmd.dir_byte, cmd.pad_byte}) <= 1)
    else $error("two byte operations at once");
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != uaw_pkg::KindError) |-> (error_code_o == 4'd0))
    else $error("error code on non-error result");
endmodule
`default_nettype wire
